/* design/mof_pkg.sv */
// Shared constants and control types of the median-of-five filter.
`default_nettype none

package mof_pkg;

  // Window of the median and depth of the sample history
  localparam int unsigned TAPS       = 5;
  localparam int unsigned HIST_DEPTH = TAPS - 1;
  // Raw samples at each end of a sequence
  localparam int unsigned EDGE       = 2;

  // Per-sequence sample count, saturating at the history depth
  localparam int unsigned CNT_W      = 3;
  localparam logic [CNT_W-1:0] CNT_EMIT   = CNT_W'(EDGE);
  localparam logic [CNT_W-1:0] CNT_MEDIAN = CNT_W'(HIST_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE    = CNT_W'(1);

  // Job queue between front and back
  localparam int unsigned Q_DEPTH    = 4;
  localparam int unsigned Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W    = $clog2(Q_DEPTH + 1);

  // Output beats one input can cause: first, previous raw, last raw
  localparam int unsigned MAX_BEATS  = 3;
  localparam int unsigned SLOT_FIRST = 0;
  localparam int unsigned SLOT_PREV  = 1;
  localparam int unsigned SLOT_LAST  = 2;

  // Classification of one accepted input
  typedef struct packed {
    logic emit_first;  // an output two samples back is due
    logic first_med;   // that output is a median, not a raw edge sample
    logic emit_prev;   // last input: previous raw sample follows
    logic is_last;     // last input: raw last sample closes the sequence
  } job_ctl_t;

endpackage

`default_nettype wire

/* design/mof_front.sv */
// Front end: accepts samples, keeps the history and classifies each input.
`default_nettype none

module mof_front #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        valid_i,
  input  logic [SAMPLE_WIDTH-1:0]                     sample_i,
  input  logic                                        is_last_i,
  input  logic                                        q_full_i,
  output logic                                        ready_o,
  output logic                                        push_o,
  output mof_pkg::job_ctl_t                           ctl_o,
  output logic [mof_pkg::TAPS-1:0][SAMPLE_WIDTH-1:0]  win_o
);
  import mof_pkg::*;

  logic [HIST_DEPTH-1:0][SAMPLE_WIDTH-1:0] hist_q;
  logic [CNT_W-1:0]                        cnt_q, cnt_d;

  assign ready_o = !q_full_i;
  assign push_o  = valid_i && !q_full_i;

  // Classify against the count of samples already seen
  always_comb begin
    ctl_o.emit_first = (cnt_q >= CNT_EMIT);
    ctl_o.first_med  = (cnt_q == CNT_MEDIAN);
    ctl_o.emit_prev  = is_last_i && (cnt_q != '0);
    ctl_o.is_last    = is_last_i;
  end

  // Window: oldest history first, new sample last
  always_comb begin
    for (int i = 0; i < HIST_DEPTH; i++) begin
      win_o[i] = hist_q[i];
    end
    win_o[TAPS-1] = sample_i;
  end

  // Count: restart after the last sample, saturate at the history depth
  always_comb begin
    cnt_d = cnt_q;
    if (push_o) begin
      if (is_last_i) begin
        cnt_d = '0;
      end else if (cnt_q != CNT_MEDIAN) begin
        cnt_d = cnt_q + CNT_ONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Shift the history; entries are only read once written in this sequence
  always_ff @(posedge clk_i) begin
    if (push_o && !is_last_i) begin
      for (int i = 0; i < HIST_DEPTH - 1; i++) begin
        hist_q[i] <= hist_q[i+1];
      end
      hist_q[HIST_DEPTH-1] <= sample_i;
    end
  end

endmodule

`default_nettype wire

/* design/mof_queue.sv */
// Short job queue between the front end and the median back end.
`default_nettype none

module mof_queue #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        push_i,
  input  mof_pkg::job_ctl_t                           ctl_i,
  input  logic [mof_pkg::TAPS-1:0][SAMPLE_WIDTH-1:0]  win_i,
  input  logic                                        pop_i,
  output logic                                        full_o,
  output logic                                        empty_o,
  output mof_pkg::job_ctl_t                           ctl_o,
  output logic [mof_pkg::TAPS-1:0][SAMPLE_WIDTH-1:0]  win_o
);
  import mof_pkg::*;

  job_ctl_t                              ctl_mem_q [Q_DEPTH];
  logic [TAPS-1:0][SAMPLE_WIDTH-1:0]     win_mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]                    wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0]                    cnt_q;

  assign full_o  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign ctl_o   = ctl_mem_q[rd_ptr_q];
  assign win_o   = win_mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + Q_CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - Q_CNT_W'(1);
      end
    end
  end

  // Store the job
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ctl_mem_q[wr_ptr_q] <= ctl_i;
      win_mem_q[wr_ptr_q] <= win_i;
    end
  end

endmodule

`default_nettype wire

/* design/mof_median.sv */
// Pipelined median-of-five compare-exchange network, stalled as one unit.
`default_nettype none

module mof_median #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        adv_i,
  input  logic                                        valid_i,
  input  mof_pkg::job_ctl_t                           ctl_i,
  input  logic [mof_pkg::TAPS-1:0][SAMPLE_WIDTH-1:0]  win_i,
  output logic                                        valid_o,
  output mof_pkg::job_ctl_t                           ctl_o,
  output logic [SAMPLE_WIDTH-1:0]                     med_o,
  output logic [SAMPLE_WIDTH-1:0]                     raw2_o,
  output logic [SAMPLE_WIDTH-1:0]                     raw3_o,
  output logic [SAMPLE_WIDTH-1:0]                     raw4_o
);
  import mof_pkg::*;

  logic                           s1_vld_q, s2_vld_q, s3_vld_q;
  job_ctl_t                       s1_ctl_q, s2_ctl_q, s3_ctl_q;
  logic [2:0][SAMPLE_WIDTH-1:0]   s1_raw_q, s2_raw_q, s3_raw_q;

  // Stage 1: sorted pairs (a<=b), (c<=d) and the new sample e
  logic signed [SAMPLE_WIDTH-1:0] s1_a_q, s1_b_q, s1_c_q, s1_d_q, s1_e_q;
  // Stage 2: sorted pair (p<=q), lone x, and e
  logic signed [SAMPLE_WIDTH-1:0] s2_p_q, s2_q_q, s2_x_q, s2_e_q;
  // Stage 3: sorted pairs (p<=q), (r<=t)
  logic signed [SAMPLE_WIDTH-1:0] s3_p_q, s3_q_q, s3_r_q, s3_t_q;

  logic signed [SAMPLE_WIDTH-1:0] w0, w1, w2, w3;
  logic                           ab_swap, cd_swap, drop_a, ex_swap;

  assign w0      = $signed(win_i[0]);
  assign w1      = $signed(win_i[1]);
  assign w2      = $signed(win_i[2]);
  assign w3      = $signed(win_i[3]);
  assign ab_swap = (w0 > w1);
  assign cd_swap = (w2 > w3);
  assign drop_a  = (s1_a_q <= s1_c_q);
  assign ex_swap = (s2_e_q > s2_x_q);

  // Advance valid bits together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (adv_i) begin
      s1_vld_q <= valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      // Stage 1: order both pairs
      s1_ctl_q <= ctl_i;
      s1_raw_q <= {win_i[4], win_i[3], win_i[2]};
      s1_a_q   <= ab_swap ? w1 : w0;
      s1_b_q   <= ab_swap ? w0 : w1;
      s1_c_q   <= cd_swap ? w3 : w2;
      s1_d_q   <= cd_swap ? w2 : w3;
      s1_e_q   <= $signed(win_i[TAPS-1]);
      // Stage 2: drop the smaller of the two pair minima
      s2_ctl_q <= s1_ctl_q;
      s2_raw_q <= s1_raw_q;
      s2_p_q   <= drop_a ? s1_c_q : s1_a_q;
      s2_q_q   <= drop_a ? s1_d_q : s1_b_q;
      s2_x_q   <= drop_a ? s1_b_q : s1_d_q;
      s2_e_q   <= s1_e_q;
      // Stage 3: pair the lone sample with e
      s3_ctl_q <= s2_ctl_q;
      s3_raw_q <= s2_raw_q;
      s3_p_q   <= s2_p_q;
      s3_q_q   <= s2_q_q;
      s3_r_q   <= ex_swap ? s2_x_q : s2_e_q;
      s3_t_q   <= ex_swap ? s2_e_q : s2_x_q;
    end
  end

  // Final: drop the smaller pair minimum again, median is the least of the rest
  always_comb begin
    if (s3_r_q <= s3_p_q) begin
      med_o = (s3_t_q <= s3_p_q) ? s3_t_q : s3_p_q;
    end else begin
      med_o = (s3_q_q <= s3_r_q) ? s3_q_q : s3_r_q;
    end
  end

  assign valid_o = s3_vld_q;
  assign ctl_o   = s3_ctl_q;
  assign raw2_o  = s3_raw_q[0];
  assign raw3_o  = s3_raw_q[1];
  assign raw4_o  = s3_raw_q[2];

endmodule

`default_nettype wire

/* design/mof_back.sv */
// Back end: runs jobs through the median network and issues their output beats.
`default_nettype none

module mof_back #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        q_empty_i,
  input  mof_pkg::job_ctl_t                           q_ctl_i,
  input  logic [mof_pkg::TAPS-1:0][SAMPLE_WIDTH-1:0]  q_win_i,
  output logic                                        q_pop_o,
  output logic                                        out_valid_o,
  input  logic                                        out_ready_i,
  output logic [SAMPLE_WIDTH-1:0]                     out_data_o,
  output logic                                        out_last_o
);
  import mof_pkg::*;

  logic                                   med_vld;
  job_ctl_t                               med_ctl;
  logic [SAMPLE_WIDTH-1:0]                med_val, raw2, raw3, raw4;
  logic [MAX_BEATS-1:0]                   pend_q, pend_d;
  logic [MAX_BEATS-1:0][SAMPLE_WIDTH-1:0] slot_q;
  logic                                   beat_done, free, adv;

  assign beat_done = out_valid_o && out_ready_i;
  // Free when empty or the only pending beat leaves now
  assign free      = (pend_q == '0) ||
                     (beat_done && ((pend_q & (pend_q - MAX_BEATS'(1))) == '0));
  assign adv       = free;
  assign q_pop_o   = adv && !q_empty_i;

  mof_median #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_median (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (!q_empty_i),
    .ctl_i   (q_ctl_i),
    .win_i   (q_win_i),
    .valid_o (med_vld),
    .ctl_o   (med_ctl),
    .med_o   (med_val),
    .raw2_o  (raw2),
    .raw3_o  (raw3),
    .raw4_o  (raw4)
  );

  // Load a finished job or drop the beat just taken
  always_comb begin
    pend_d = pend_q;
    if (adv) begin
      if (med_vld) begin
        pend_d[SLOT_FIRST] = med_ctl.emit_first;
        pend_d[SLOT_PREV]  = med_ctl.emit_prev;
        pend_d[SLOT_LAST]  = med_ctl.is_last;
      end else begin
        pend_d = '0;
      end
    end else if (beat_done) begin
      pend_d = pend_q & (pend_q - MAX_BEATS'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && med_vld) begin
      slot_q[SLOT_FIRST] <= med_ctl.first_med ? med_val : raw2;
      slot_q[SLOT_PREV]  <= raw3;
      slot_q[SLOT_LAST]  <= raw4;
    end
  end

  // Present the oldest pending beat
  assign out_valid_o = (pend_q != '0);
  always_comb begin
    if (pend_q[SLOT_FIRST]) begin
      out_data_o = slot_q[SLOT_FIRST];
      out_last_o = 1'b0;
    end else if (pend_q[SLOT_PREV]) begin
      out_data_o = slot_q[SLOT_PREV];
      out_last_o = 1'b0;
    end else begin
      out_data_o = slot_q[SLOT_LAST];
      out_last_o = pend_q[SLOT_LAST];
    end
  end

endmodule

`default_nettype wire

/* design/median_of_five_filter.sv */
// Top level of the sliding median-of-five stream filter.
//
//   channel   direction  tdata (low bit up)         tlast
//   s_axis    in         sample [SAMPLE_WIDTH-1:0]  is_last
//   m_axis    out        filtered [SAMPLE_WIDTH-1:0] last_out
//
// One input beat is taken per cycle while the four-entry job queue has room.
// Each beat passes the queue, three network registers and the output slots
// before its first output beat is offered.
// A last sample causes up to three output beats, one per cycle while the
// output is ready, and holds the network until its last beat is taken.
// Output stalls back up through the network into the queue before the input
// side is held. Reset clears the count, the queue and all valid bits at once.
`default_nettype none

module median_of_five_filter #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      s_axis_tdata_i,  // sample
  input  logic                                   s_axis_tlast_i,  // is_last
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      m_axis_tdata_o,  // filtered
  output logic                                   m_axis_tlast_o   // last_out
);
  import mof_pkg::*;

  localparam int unsigned DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

  logic                              push, pop, q_full, q_empty;
  job_ctl_t                          f_ctl, q_ctl;
  logic [TAPS-1:0][SAMPLE_WIDTH-1:0] f_win, q_win;
  logic [SAMPLE_WIDTH-1:0]           out_data;

  mof_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid_i),
    .sample_i  (s_axis_tdata_i[SAMPLE_WIDTH-1:0]),
    .is_last_i (s_axis_tlast_i),
    .q_full_i  (q_full),
    .ready_o   (s_axis_tready_o),
    .push_o    (push),
    .ctl_o     (f_ctl),
    .win_o     (f_win)
  );

  mof_queue #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ctl_i   (f_ctl),
    .win_i   (f_win),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .ctl_o   (q_ctl),
    .win_o   (q_win)
  );

  mof_back #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_ctl_i     (q_ctl),
    .q_win_i     (q_win),
    .q_pop_o     (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (out_data),
    .out_last_o  (m_axis_tlast_o)
  );

  // Zero-fill the beat to whole bytes
  assign m_axis_tdata_o = DATA_W'(out_data);

endmodule

`default_nettype wire
